// ----- rtl/crc16_pkg.sv -----
// ============================================================================
// crc16_pkg
// Shared types, constants and the byte absorb function for the reflected
// 16-bit CRC engine.
// ============================================================================
package crc16_pkg;

    localparam int DATA_W     = 8;
    localparam int CRC_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [CRC_W-1:0] POLY_RESET = 16'hA001;
    localparam logic [CRC_W-1:0] SEED_RESET = 16'h0000;

    // register index, taken from the word address
    typedef enum logic [0:0] {
        REG_POLY = 1'b0,
        REG_SEED = 1'b1
    } t_reg_idx;

    // one classified item between front and back
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              reload;
        logic              last;
    } t_cmd;

    // xor the byte into the low bits, then eight lsb-first shift steps
    function automatic logic [CRC_W-1:0] crc16_absorb(
        input logic [CRC_W-1:0]  crc_in,
        input logic [CRC_W-1:0]  poly,
        input logic [DATA_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
        for (int step = 0; step < DATA_W; step++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ poly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/crc16_ifs.sv -----
// ============================================================================
// crc16 stream interfaces
// Valid/ready channels for input bytes and for CRC results.
// ============================================================================
interface crc16_in_if;
    logic                           valid;
    logic                           ready;
    logic [crc16_pkg::DATA_W-1:0]   data_byte;
    logic                           first_byte;
    logic                           last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface crc16_out_if;
    logic                           valid;
    logic                           ready;
    logic [crc16_pkg::CRC_W-1:0]    crc_value;
    logic                           crc_final;

    modport source (output valid, crc_value, crc_final, input ready);
    modport sink   (input valid, crc_value, crc_final, output ready);
endinterface

// ----- rtl/crc16_front.sv -----
// ============================================================================
// crc16_front
// Accepts input items, classifies them as seed reload or continue, and
// registers them for the command queue.
// ============================================================================
module crc16_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    crc16_in_if.sink          i_in,
    output logic              o_push_valid,
    output crc16_pkg::t_cmd   o_push_cmd,
    input  logic              i_push_ready
);

    logic            r_valid;
    logic            n_valid;
    crc16_pkg::t_cmd r_cmd;
    logic            accept;

    // take a new item whenever the holding stage is empty or drains now
    assign i_in.ready = !r_valid || i_push_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture with classification
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.data_byte <= i_in.data_byte;
            r_cmd.reload    <= i_in.first_byte;
            r_cmd.last      <= i_in.last_byte;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

// ----- rtl/crc16_queue.sv -----
// ============================================================================
// crc16_queue
// Short command queue that decouples the front stage from the CRC back end.
// ============================================================================
module crc16_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  crc16_pkg::t_cmd   i_push_cmd,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output crc16_pkg::t_cmd   o_pop_cmd,
    input  logic              i_pop
);

    crc16_pkg::t_cmd                    r_mem [crc16_pkg::FIFO_DEPTH];
    logic [crc16_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [crc16_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [crc16_pkg::FIFO_CNT_W-1:0]   r_count;
    logic [crc16_pkg::FIFO_PTR_W-1:0]   n_wr_ptr;
    logic [crc16_pkg::FIFO_PTR_W-1:0]   n_rd_ptr;
    logic [crc16_pkg::FIFO_CNT_W-1:0]   n_count;
    logic                               push;
    logic                               pop;

    localparam logic [crc16_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        crc16_pkg::FIFO_PTR_W'(crc16_pkg::FIFO_DEPTH - 1);
    localparam logic [crc16_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        crc16_pkg::FIFO_CNT_W'(crc16_pkg::FIFO_DEPTH);

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/crc16_back.sv -----
// ============================================================================
// crc16_back
// Holds the running CRC, absorbs one byte per cycle unless the result
// register is held, and registers the result for the output channel.
// ============================================================================
module crc16_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  crc16_pkg::t_cmd               i_cmd,
    output logic                          o_pop,
    input  logic [crc16_pkg::CRC_W-1:0]   i_poly,
    input  logic [crc16_pkg::CRC_W-1:0]   i_seed,
    crc16_out_if.source                   o_out
);

    logic [crc16_pkg::CRC_W-1:0] r_crc;
    logic [crc16_pkg::CRC_W-1:0] n_crc;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [crc16_pkg::CRC_W-1:0] r_out_crc;
    logic                        r_out_final;
    logic [crc16_pkg::CRC_W-1:0] base;

    // work on the next item when the result register is free or drains now
    assign o_pop = i_cmd_valid && (!r_out_valid || o_out.ready);

    // seed reload, then the unrolled byte absorb
    always_comb begin
        base        = i_cmd.reload ? i_seed : r_crc;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_crc       = crc16_pkg::crc16_absorb(base, i_poly, i_cmd.data_byte);
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_crc   <= n_crc;
            r_out_final <= i_cmd.last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.crc_value = r_out_crc;
    assign o_out.crc_final = r_out_final;

endmodule

// ----- rtl/crc16_reflected_engine.sv -----
// ============================================================================
// crc16_reflected_engine
// Reflected 16-bit CRC over a byte stream with programmable polynomial
// and seed.
// ============================================================================
// Usage:
//   i_in carries one byte per item with first_byte and last_byte flags.
//   first_byte reloads the seed before the byte is absorbed.
//   o_out returns one item per input byte: the updated CRC and crc_final,
//   a copy of last_byte, which marks the finished message CRC.
//   Polynomial (address 0) and seed (address 4) are written over the APB
//   port while no item is in flight; reads return the current values.
//   Throughput: one byte per cycle while o_out.ready is high; the eight
//   shift steps of one byte are unrolled in the back end between the queue
//   head and the result register.
//   A two-entry queue sits between the input stage and the CRC back end.
//   When o_out.ready is low the result holds, the queue fills, and i_in.ready
//   drops only once the input stage also holds an item.
//   Reset (synchronous, active low) empties all stages, clears the running
//   CRC to zero and restores polynomial 0xA001 and seed 0x0000.
// ============================================================================
module crc16_reflected_engine (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    crc16_in_if.sink                              i_in,
    crc16_out_if.source                           o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crc16_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [crc16_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [crc16_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    logic [crc16_pkg::CRC_W-1:0] r_poly;
    logic [crc16_pkg::CRC_W-1:0] r_seed;
    logic [crc16_pkg::CRC_W-1:0] n_poly;
    logic [crc16_pkg::CRC_W-1:0] n_seed;
    crc16_pkg::t_reg_idx         reg_idx;
    logic                        wr_en;

    logic                        push_valid;
    crc16_pkg::t_cmd             push_cmd;
    logic                        push_ready;
    logic                        pop_valid;
    crc16_pkg::t_cmd             pop_cmd;
    logic                        pop;

    // register file: word address selects the register
    assign pready  = 1'b1;
    assign reg_idx = crc16_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_poly = r_poly;
        n_seed = r_seed;
        if (wr_en) begin
            unique case (reg_idx)
                crc16_pkg::REG_POLY: n_poly = pwdata[crc16_pkg::CRC_W-1:0];
                crc16_pkg::REG_SEED: n_seed = pwdata[crc16_pkg::CRC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= crc16_pkg::POLY_RESET;
            r_seed <= crc16_pkg::SEED_RESET;
        end else begin
            r_poly <= n_poly;
            r_seed <= n_seed;
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            crc16_pkg::REG_POLY: prdata = {{(crc16_pkg::APB_DATA_W-crc16_pkg::CRC_W){1'b0}},
                                           r_poly};
            crc16_pkg::REG_SEED: prdata = {{(crc16_pkg::APB_DATA_W-crc16_pkg::CRC_W){1'b0}},
                                           r_seed};
            default:             prdata = '0;
        endcase
    end

    // input stage
    crc16_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    // command queue
    crc16_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    // crc back end
    crc16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .i_poly      (r_poly),
        .i_seed      (r_seed),
        .o_out       (o_out)
    );

endmodule

// ----- tb/crc16_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crc16_checker
// Watches the byte and result channels and the register port of the CRC
// engine, keeps its own copy of polynomial, seed and running CRC, and
// compares every result item and register read against the prediction.
// ============================================================================
module crc16_checker
    import crc16_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    crc16_in_if                   i_in,
    crc16_out_if                  i_res,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic             is_final;
    } t_crc_result;

    logic [CRC_W-1:0] poly_shadow;
    logic [CRC_W-1:0] seed_shadow;
    logic [CRC_W-1:0] running_crc;
    t_crc_result      crc_expect_q[$];
    int               err_total = 0;

    // lsb-first absorb of one byte, polynomial applied when a one falls out
    function automatic logic [CRC_W-1:0] crc_after_byte(
        input logic [CRC_W-1:0]  start,
        input logic [CRC_W-1:0]  poly,
        input logic [DATA_W-1:0] data
    );
        logic [CRC_W-1:0] acc;
        logic             out_bit;
        acc = start ^ CRC_W'(data);
        for (int k = 0; k < DATA_W; k++) begin
            out_bit = acc[0];
            acc     = {1'b0, acc[CRC_W-1:1]} ^ (out_bit ? poly : '0);
        end
        return acc;
    endfunction

    // count a failure, report only the first few
    function automatic bit report_now();
        err_total++;
        return err_total <= REPORT_LIMIT;
    endfunction

    always @(posedge i_clk) begin
        t_crc_result      got;
        t_crc_result      want;
        logic [CRC_W-1:0] reg_val;
        t_reg_idx         idx;
        if (!i_rst_n) begin
            poly_shadow = POLY_RESET;
            seed_shadow = SEED_RESET;
            running_crc = '0;
            crc_expect_q.delete();
        end else begin
            idx = t_reg_idx'(i_paddr[2]);

            // register port: track writes, compare reads
            if (i_psel && i_penable && i_pready && i_pwrite) begin
                case (idx)
                    REG_POLY: poly_shadow = i_pwdata[CRC_W-1:0];
                    REG_SEED: seed_shadow = i_pwdata[CRC_W-1:0];
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pready && !i_pwrite) begin
                reg_val = (idx == REG_POLY) ? poly_shadow : seed_shadow;
                if (i_prdata !== APB_DATA_W'(reg_val)) begin
                    if (report_now())
                        $display("[%0t] register %s read: expected %h, got %h",
                                 $realtime, idx.name(), APB_DATA_W'(reg_val), i_prdata);
                end
            end

            // result side first, so an item accepted now cannot match itself
            if (i_res.valid && i_res.ready) begin
                got.crc      = i_res.crc_value;
                got.is_final = i_res.crc_final;
                if (crc_expect_q.size() == 0) begin
                    if (report_now())
                        $display("[%0t] unexpected result item: crc=%h final=%b",
                                 $realtime, got.crc, got.is_final);
                end else begin
                    want = crc_expect_q.pop_front();
                    if (got.crc !== want.crc || got.is_final !== want.is_final) begin
                        if (report_now())
                            $display("[%0t] result mismatch: expected %h/%b, got %h/%b",
                                     $realtime, want.crc, want.is_final, got.crc, got.is_final);
                    end
                end
            end

            // byte side: seed reload on first byte, then absorb
            if (i_in.valid && i_in.ready) begin
                if (i_in.first_byte)
                    running_crc = seed_shadow;
                running_crc   = crc_after_byte(running_crc, poly_shadow, i_in.data_byte);
                want.crc      = running_crc;
                want.is_final = i_in.last_byte;
                crc_expect_q.push_back(want);
            end
        end
        o_pending    <= crc_expect_q.size();
        o_fail_count <= err_total;
    end

endmodule

// ----- tb/tb_crc16_reflected_engine.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_crc16_reflected_engine
// Drives byte items and register accesses into the CRC engine with random
// bursts, gaps and result stalls, including one long stall that backs the
// engine up; the checker beside the engine predicts and compares.
// ============================================================================
module tb_crc16_reflected_engine;
    import crc16_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 250;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;
    int                    burst_left = 0;
    bit                    steady_send = 1'b0;
    bit                    hold_off_req = 1'b0;
    bit                    hold_off_done = 1'b0;

    crc16_in_if  byte_ch ();
    crc16_out_if crc_ch ();

    always #5 clk = ~clk;

    crc16_reflected_engine DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (crc_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    crc16_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (byte_ch),
        .i_res        (crc_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // one register transfer: setup cycle, then access until pready
    task automatic reg_access(input bit write_en, input t_reg_idx idx,
                              input logic [CRC_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write_en;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // wait until every expected result is back, then program and read back
    task automatic program_crc(input logic [CRC_W-1:0] poly,
                               input logic [CRC_W-1:0] seed);
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        reg_access(1'b1, REG_POLY, poly);
        reg_access(1'b1, REG_SEED, seed);
        reg_access(1'b0, REG_POLY, '0);
        reg_access(1'b0, REG_SEED, '0);
    endtask

    // offer one byte item, with a random gap at the end of each burst
    task automatic send_byte(input logic [DATA_W-1:0] data, input logic first,
                             input logic last);
        int gap;
        @(negedge clk);
        if (!steady_send && burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            byte_ch.valid      = 1'b0;
            byte_ch.data_byte  = DATA_W'($urandom);
            byte_ch.first_byte = 1'($urandom_range(0, 1));
            byte_ch.last_byte  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        byte_ch.valid      = 1'b1;
        byte_ch.data_byte  = data;
        byte_ch.first_byte = first;
        byte_ch.last_byte  = last;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    // result side: ready pattern changes mode now and then, plus one long hold
    initial begin
        int mode_left;
        int ready_pct;
        mode_left    = 0;
        ready_pct    = 100;
        crc_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                crc_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(20, 300);
                    case ($urandom_range(0, 4))
                        0, 1:    ready_pct = 100;
                        2:       ready_pct = 75;
                        3:       ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                mode_left--;
                crc_ch.ready = ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // no progress on either channel for too long ends the run
    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (crc_ch.valid && crc_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [CRC_W-1:0] poly_pick;
        logic [CRC_W-1:0] seed_pick;
        int               msg_len;
        int               sent;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.first_byte = 1'b0;
        byte_ch.last_byte  = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        rst_n              = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset settings, bytes before any first byte
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        // one-byte message
        send_byte(8'h5A, 1'b1, 1'b1);
        send_byte(8'h31, 1'b1, 1'b0);
        send_byte(8'h32, 1'b0, 1'b0);
        send_byte(8'h33, 1'b0, 1'b1);
        // continuing after a last byte without a new first byte
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1);
        // registers changed in the middle of a message
        send_byte(8'h12, 1'b1, 1'b0);
        program_crc(16'h8408, 16'hFFFF);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b1);
        // all-ones and all-zeros settings
        program_crc(16'hFFFF, 16'hFFFF);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h7F, 1'b1, 1'b1);
        program_crc(16'h0000, 16'h0000);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b1);

        // random phases: mostly framed messages, some stray bytes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       poly_pick = 16'h0000;
                1:       poly_pick = 16'hFFFF;
                2:       poly_pick = POLY_RESET;
                3:       poly_pick = 16'h8408;
                default: poly_pick = CRC_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       seed_pick = 16'h0000;
                1:       seed_pick = 16'hFFFF;
                default: seed_pick = CRC_W'($urandom);
            endcase
            program_crc(poly_pick, seed_pick);

            // long result stall while bytes keep coming, so the engine backs up
            if (phase == 2) begin
                steady_send  = 1'b1;
                hold_off_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (steady_send && sent >= 40)
                    steady_send = 1'b0;
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40)
                                                          : $urandom_range(1, 8);
                    for (int i = 0; i < msg_len; i++)
                        send_byte(DATA_W'($urandom), i == 0, i == msg_len - 1);
                    sent += msg_len;
                end
            end
        end

        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
